/* rtl/core/lrc_pkg.sv */
// Shared constants, types and controller/datapath links for the register cache.
// No dependencies; compiled first.
`default_nettype none

package lrc_pkg;

    localparam int NUM_REGS    = 8;
    localparam int KEY_WIDTH   = 16;
    localparam int IDX_W       = $clog2(NUM_REGS);
    localparam int CNT_W       = $clog2(NUM_REGS + 1);

    // fixed field widths of the channels
    localparam int KEY_FIELD_W = 16;
    localparam int RIDX_W      = 4;
    localparam int WREG_W      = 3;

    localparam logic OP_ALLOC  = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef logic [KEY_WIDTH-1:0] t_key;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;

    typedef struct packed {
        logic accept;
        logic exec;
    } t_dp_cmd;

    typedef struct packed {
        logic produce;
        logic out_last;
    } t_dp_stat;

endpackage

`default_nettype wire

/* rtl/core/lrc_if.sv */
// Request and response channel interfaces (valid/ready with payload).
// Depends on lrc_pkg.
`default_nettype none

interface lrc_req_if import lrc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   operation;
    logic [KEY_FIELD_W-1:0] key;
    logic                   return_slot;
    logic                   mark_dirty;

    modport source (output valid, operation, key, return_slot, mark_dirty, input ready);
    modport sink   (input valid, operation, key, return_slot, mark_dirty, output ready);
endinterface

interface lrc_rsp_if import lrc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [RIDX_W-1:0]      reg_index;
    logic                   hit;
    logic                   need_load;
    logic                   need_writeback;
    logic [KEY_FIELD_W-1:0] writeback_key;
    logic [WREG_W-1:0]      writeback_reg;
    logic                   last;

    modport source (output valid, reg_index, hit, need_load, need_writeback,
                    writeback_key, writeback_reg, last, input ready);
    modport sink   (input valid, reg_index, hit, need_load, need_writeback,
                    writeback_key, writeback_reg, last, output ready);
endinterface

`default_nettype wire

/* rtl/core/lrc_ctrl.sv */
// Register cache sequencer: accept, execute steps, present any results.
// Depends on lrc_pkg.
`default_nettype none

module lrc_ctrl import lrc_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire logic     i_out_ready,
    output logic          o_out_valid,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       exec;

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        exec        = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                exec    = 1'b1;
                n_state = i_stat.produce ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                o_in_ready  = i_out_ready && i_stat.out_last;
                if (i_out_ready) begin
                    if (!i_stat.out_last) begin
                        n_state = S_EXEC;
                    end else if (i_in_valid) begin
                        n_state = S_EXEC;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd.accept = i_in_valid && o_in_ready;
    assign o_cmd.exec   = exec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_exec_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_state != S_EXEC))
        else $error("execute step repeated");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !i_out_ready) |=> (r_state == S_OUT))
        else $error("result dropped while stalled");

    a_no_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> !o_in_ready)
        else $error("request accepted during execute step");

endmodule

`default_nettype wire

/* rtl/core/lrc_datapath.sv */
// Register cache datapath: recency-ordered entries, lookup, replacement,
// flush walk and the result register. Depends on lrc_pkg.
`default_nettype none

module lrc_datapath import lrc_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_dp_cmd                i_cmd,
    output t_dp_stat                    o_stat,
    input  wire logic                   i_operation,
    input  wire logic [KEY_FIELD_W-1:0] i_key,
    input  wire logic                   i_return_slot,
    input  wire logic                   i_mark_dirty,
    output logic [RIDX_W-1:0]           o_reg_index,
    output logic                        o_hit,
    output logic                        o_need_load,
    output logic                        o_need_writeback,
    output logic [KEY_FIELD_W-1:0]      o_writeback_key,
    output logic [WREG_W-1:0]           o_writeback_reg,
    output logic                        o_last
);

    // latched request
    logic r_op;
    t_key r_key;
    logic r_ret;
    logic r_mark;
    t_cnt r_walk;

    // entries, slot 0 most recent
    t_key                r_ekey [NUM_REGS];
    t_idx                r_ereg [NUM_REGS];
    logic [NUM_REGS-1:0] r_dirty;
    logic [NUM_REGS-1:0] r_in_use;
    t_cnt                r_count;

    // result register
    logic [RIDX_W-1:0]      r_o_reg_index, n_o_reg_index;
    logic                   r_o_hit, n_o_hit;
    logic                   r_o_load, n_o_load;
    logic                   r_o_wb, n_o_wb;
    logic [KEY_FIELD_W-1:0] r_o_wkey, n_o_wkey;
    logic [WREG_W-1:0]      r_o_wreg, n_o_wreg;
    logic                   r_o_last, n_o_last;

    logic [NUM_REGS-1:0] valid;
    logic [NUM_REGS-1:0] match;
    logic [NUM_REGS-1:0] dv;
    logic                hit;
    t_idx                hit_pos;
    t_idx                free_reg;
    logic                full;
    logic                found;
    t_idx                fpos;
    logic                more;
    logic                f_last;
    t_idx                pos;
    t_idx                rd_idx;
    t_key                rd_key;
    t_idx                rd_reg;
    logic                rd_dirty;
    logic                is_flush;
    logic                alloc_upd;
    logic                insert;
    logic                clear;

    always_comb begin
        hit      = 1'b0;
        hit_pos  = '0;
        free_reg = '0;
        found    = 1'b0;
        fpos     = '0;
        more     = 1'b0;
        for (int i = NUM_REGS - 1; i >= 0; i--) begin
            valid[i] = CNT_W'(i) < r_count;
            match[i] = valid[i] && (r_ekey[i] == r_key);
            dv[i]    = r_dirty[i] && valid[i] && (CNT_W'(i) >= r_walk);
            if (match[i]) begin
                hit     = 1'b1;
                hit_pos = IDX_W'(i);
            end
            if (!r_in_use[i]) begin
                free_reg = IDX_W'(i);
            end
            if (dv[i]) begin
                found = 1'b1;
                fpos  = IDX_W'(i);
            end
        end
        for (int i = 0; i < NUM_REGS; i++) begin
            if (dv[i] && (IDX_W'(i) > fpos)) begin
                more = 1'b1;
            end
        end
    end

    assign full      = (r_count == CNT_W'(NUM_REGS));
    assign f_last    = found && !more;
    assign is_flush  = (r_op == OP_FLUSH);
    assign pos       = hit ? hit_pos : (full ? IDX_W'(NUM_REGS - 1) : r_count[IDX_W-1:0]);
    assign rd_idx    = is_flush ? fpos : pos;
    assign rd_key    = r_ekey[rd_idx];
    assign rd_reg    = r_ereg[rd_idx];
    assign rd_dirty  = r_dirty[rd_idx];
    assign alloc_upd = i_cmd.exec && !is_flush && !r_ret;
    assign insert    = alloc_upd && !hit && !full;
    assign clear     = i_cmd.exec && is_flush && (!found || f_last);

    assign o_stat.produce  = is_flush ? found : 1'b1;
    assign o_stat.out_last = r_o_last;

    always_comb begin
        n_o_reg_index = '0;
        n_o_hit       = 1'b0;
        n_o_load      = 1'b0;
        n_o_wb        = 1'b0;
        n_o_wkey      = '0;
        n_o_wreg      = '0;
        n_o_last      = 1'b1;
        if (is_flush) begin
            n_o_wb   = 1'b1;
            n_o_wkey = KEY_FIELD_W'(rd_key);
            n_o_wreg = WREG_W'(rd_reg);
            n_o_last = f_last;
        end else if (r_ret) begin
            n_o_reg_index = RIDX_W'(NUM_REGS);
        end else if (hit) begin
            n_o_reg_index = RIDX_W'(rd_reg);
            n_o_hit       = 1'b1;
        end else if (!full) begin
            n_o_reg_index = RIDX_W'(free_reg);
            n_o_load      = 1'b1;
        end else begin
            n_o_reg_index = RIDX_W'(rd_reg);
            n_o_load      = 1'b1;
            n_o_wb        = rd_dirty;
            n_o_wkey      = rd_dirty ? KEY_FIELD_W'(rd_key) : '0;
            n_o_wreg      = rd_dirty ? WREG_W'(rd_reg) : '0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_operation;
            r_key  <= KEY_WIDTH'(i_key);
            r_ret  <= i_return_slot;
            r_mark <= i_mark_dirty;
        end
        if (i_cmd.accept) begin
            r_walk <= '0;
        end else if (i_cmd.exec && is_flush && found) begin
            r_walk <= CNT_W'(fpos) + CNT_W'(1);
        end
        if (alloc_upd) begin
            for (int i = 1; i < NUM_REGS; i++) begin
                if (IDX_W'(i) <= pos) begin
                    r_ekey[i] <= r_ekey[i-1];
                    r_ereg[i] <= r_ereg[i-1];
                end
            end
            r_ekey[0] <= hit ? rd_key : r_key;
            r_ereg[0] <= (hit || full) ? rd_reg : free_reg;
        end
        if (i_cmd.exec && o_stat.produce) begin
            r_o_reg_index <= n_o_reg_index;
            r_o_hit       <= n_o_hit;
            r_o_load      <= n_o_load;
            r_o_wb        <= n_o_wb;
            r_o_wkey      <= n_o_wkey;
            r_o_wreg      <= n_o_wreg;
        end
    end

    // occupancy and dirty marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty  <= '0;
            r_in_use <= '0;
            r_count  <= '0;
            r_o_last <= 1'b0;
        end else begin
            if (i_cmd.exec && o_stat.produce) begin
                r_o_last <= n_o_last;
            end
            if (clear) begin
                r_dirty  <= '0;
                r_in_use <= '0;
                r_count  <= '0;
            end else if (alloc_upd) begin
                for (int i = 1; i < NUM_REGS; i++) begin
                    if (IDX_W'(i) <= pos) begin
                        r_dirty[i] <= r_dirty[i-1];
                    end
                end
                r_dirty[0] <= hit ? (rd_dirty | r_mark) : r_mark;
                if (insert) begin
                    r_in_use[free_reg] <= 1'b1;
                    r_count            <= r_count + CNT_W'(1);
                end
            end
        end
    end

    assign o_reg_index      = r_o_reg_index;
    assign o_hit            = r_o_hit;
    assign o_need_load      = r_o_load;
    assign o_need_writeback = r_o_wb;
    assign o_writeback_key  = r_o_wkey;
    assign o_writeback_reg  = r_o_wreg;
    assign o_last           = r_o_last;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(NUM_REGS))
        else $error("resident count out of range");

    a_count_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_in_use) == int'(r_count))
        else $error("register use map disagrees with resident count");

    a_alloc_resident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alloc_upd |=> (r_count != '0))
        else $error("allocation left the store empty");

endmodule

`default_nettype wire

/* rtl/core/lru_register_cache_writeback.sv */
// Top level of the eight-entry LRU register cache with write-back.
// Depends on lrc_pkg, lrc_if, lrc_ctrl, lrc_datapath.
//
// channel  dir  modport  payload
// i_req    in   sink     operation, key, return_slot, mark_dirty
// o_rsp    out  source   reg_index, hit, need_load, need_writeback,
//                        writeback_key, writeback_reg, last
//
// Allocate and return-slot requests each take one execute step (for an
// allocate, the compare and recency update), then the result register; the
// next request is taken in the cycle the result transfers. A flush takes one
// execute step and one result per dirty entry; when none is dirty it takes
// one execute step and presents no result.
// Reset is synchronous and clears occupancy and dirty marks; entry keys and
// registers are not cleared. A stalled result holds in the output register.
`default_nettype none

module lru_register_cache_writeback import lrc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lrc_req_if.sink    i_req,
    lrc_rsp_if.source  o_rsp
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    lrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    lrc_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_operation      (i_req.operation),
        .i_key            (i_req.key),
        .i_return_slot    (i_req.return_slot),
        .i_mark_dirty     (i_req.mark_dirty),
        .o_reg_index      (o_rsp.reg_index),
        .o_hit            (o_rsp.hit),
        .o_need_load      (o_rsp.need_load),
        .o_need_writeback (o_rsp.need_writeback),
        .o_writeback_key  (o_rsp.writeback_key),
        .o_writeback_reg  (o_rsp.writeback_reg),
        .o_last           (o_rsp.last)
    );

endmodule

`default_nettype wire
